// ----- hdl/lec_pkg.sv -----
// Shared types and constants for the light episode counter.
// Used by the register block, the episode logic, the top level and the checker.
package lec_pkg;

    localparam int SAMPLE_W = 12;
    localparam int HOLD_W   = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [SAMPLE_W-1:0] ON_THR_RESET    = 12'd1241;
    localparam logic [SAMPLE_W-1:0] OFF_THR_RESET   = 12'd620;
    localparam logic [HOLD_W-1:0]   DARK_HOLD_RESET = 16'd500;

    typedef enum logic [1:0] {
        REG_ON_THR    = 2'd0,
        REG_OFF_THR   = 2'd1,
        REG_DARK_HOLD = 2'd2
    } reg_idx_t;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_CLEAR  = 1'b1
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] on_threshold;
        logic [SAMPLE_W-1:0] off_threshold;
        logic [HOLD_W-1:0]   dark_hold_ms;
    } cfg_t;

    typedef struct packed {
        mode_t               mode;
        logic [SAMPLE_W-1:0] sample;
        logic                edge_seen;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic               light_on;
        logic               episode_active;
        logic               new_episode;
        logic [COUNT_W-1:0] episode_total;
    } result_t;

endpackage

// ----- hdl/lec_cfg_regs.sv -----
// APB configuration registers of the light episode counter.
// Depends on lec_pkg for the register map and the configuration struct.
module lec_cfg_regs
    import lec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ON_THR:    cfg_next.on_threshold  = pwdata[SAMPLE_W-1:0];
                REG_OFF_THR:   cfg_next.off_threshold = pwdata[SAMPLE_W-1:0];
                REG_DARK_HOLD: cfg_next.dark_hold_ms  = pwdata[HOLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ON_THR:    prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, cfg_reg.on_threshold};
            REG_OFF_THR:   prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, cfg_reg.off_threshold};
            REG_DARK_HOLD: prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, cfg_reg.dark_hold_ms};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold  <= ON_THR_RESET;
            cfg_reg.off_threshold <= OFF_THR_RESET;
            cfg_reg.dark_hold_ms  <= DARK_HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/lec_episode_logic.sv -----
// Hysteresis comparator, dark timer, episode latch and episode count.
// Depends on lec_pkg; state advances once for each item passed in with step high.
module lec_episode_logic
    import lec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    step,
    output result_t result
);

    logic               light_reg;
    logic               light_next;
    logic               timing_reg;
    logic               timing_next;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  start_next;
    logic               latch_reg;
    logic               latch_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               counted;
    logic               light_cmp;
    logic [TIME_W-1:0]  elapsed;

    always_comb
    begin
        light_next  = light_reg;
        timing_next = timing_reg;
        start_next  = start_reg;
        latch_next  = latch_reg;
        count_next  = count_reg;
        counted     = 1'b0;
        light_cmp   = light_reg ? (item.sample > cfg.off_threshold)
                                : (item.sample >= cfg.on_threshold);
        elapsed     = '0;
        if (item.mode == MODE_CLEAR)
        begin
            latch_next = 1'b0;
            count_next = '0;
        end
        else
        begin
            light_next = light_cmp;
            if (!light_cmp)
            begin
                timing_next = 1'b1;
                if (!timing_reg)
                begin
                    start_next = item.now_ms;
                end
                elapsed = item.now_ms - start_next;
                if (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, cfg.dark_hold_ms})
                begin
                    latch_next = 1'b0;
                end
            end
            else
            begin
                timing_next = 1'b0;
                if (item.edge_seen && !latch_reg)
                begin
                    latch_next = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    counted    = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.light_on       = light_next;
        result.episode_active = latch_next;
        result.new_episode    = counted;
        result.episode_total  = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg  <= 1'b0;
            timing_reg <= 1'b0;
            start_reg  <= '0;
            latch_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            light_reg  <= light_next;
            timing_reg <= timing_next;
            start_reg  <= start_next;
            latch_reg  <= latch_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/light_episode_counter.sv -----
// Light episode counter: one result for every input transfer. An item is taken into an
// input register, evaluated combinationally against the comparator, dark timer and latch
// state, and its result is held in an output register, from which the result is offered
// once the item can leave the input register.
// A new item is accepted every cycle as long as the output register is empty or being
// drained; the output register alone sets the stall point.
// The user writes configuration over APB only while no item is in flight; the block does not enforce this.
module light_episode_counter
    import lec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] sample, [12] edge_seen, [44:13] now_ms, [47:45] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] light_on, [1] episode_active, [2] new_episode, [34:3] episode_total, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_comb;
    logic    advance;
    logic    in_xfer;

    lec_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lec_episode_logic u_episode (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .step   (advance),
        .result (res_comb)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next           = item_reg;
        item_next.mode      = mode_t'(s_axis_tuser);
        item_next.sample    = s_axis_tdata[11:0];
        item_next.edge_seen = s_axis_tdata[12];
        item_next.now_ms    = s_axis_tdata[44:13];
        in_valid_next       = in_xfer || (in_valid_reg && !advance);
        out_valid_next      = advance || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-COUNT_W-3){1'b0}}, res_reg.episode_total,
                            res_reg.new_episode, res_reg.episode_active, res_reg.light_on};

endmodule

// ----- hdl/lec_checker.sv -----
// Port-level checks for the light episode counter, bound to the top level.
// Depends only on the top level's ports and widths from lec_pkg.
module lec_checker
    import lec_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output transfer changed.");

    a_new_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("New episode reported with the latch released.");

    a_new_needs_light: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0])
        else $error("New episode reported while dark.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled while the output register is empty.");

endmodule

bind light_episode_counter lec_checker u_lec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
